>>> hw/rtl/yuv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Shared types and coefficients for the BT.601 video-range YUV to RGB pipeline.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

    // input mode codes (any code with bit 1 set selects the packed word)
    localparam logic [1:0] MODE_FULL   = 2'd0;
    localparam logic [1:0] MODE_QUANT  = 2'd1;
    localparam logic [1:0] MODE_PACKED = 2'd2;

    // conversion coefficients, scaled by 256
    localparam logic signed [10:0] COEF_Y  = 11'sd298;
    localparam logic signed [10:0] COEF_RV = 11'sd409;
    localparam logic signed [10:0] COEF_GU = 11'sd100;
    localparam logic signed [10:0] COEF_GV = 11'sd208;
    localparam logic signed [10:0] COEF_BU = 11'sd516;

    // sample offsets, rounding term and clip limit
    localparam logic [7:0]         LUMA_OFFSET   = 8'd16;
    localparam logic [7:0]         CHROMA_OFFSET = 8'd128;
    localparam logic signed [8:0]  ROUND_BIAS    = 9'sd128;
    localparam logic signed [11:0] CLIP_MAX      = 12'sd255;

    // offset samples after the front end
    typedef struct packed {
        logic signed [8:0] c;   // y - 16
        logic signed [7:0] d;   // u - 128
        logic signed [7:0] e;   // v - 128
    } offs_t;

    // scaled terms after the multiplier stage
    typedef struct packed {
        logic signed [17:0] y_term;    // 298 * c
        logic signed [16:0] rv_term;   // 409 * e
        logic signed [14:0] gu_term;   // 100 * d
        logic signed [15:0] gv_term;   // 208 * e
        logic signed [17:0] bu_term;   // 516 * d
    } prod_t;

endpackage

>>> hw/rtl/yuv2rgb_unpack.sv
// ----------------------------------------------------------------------------
// yuv2rgb_unpack
// Stage 1: selects the sample source by mode, re-expands quantized samples
// and removes the video-range offsets.
// ----------------------------------------------------------------------------
module yuv2rgb_unpack
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           mode,
    input  logic [7:0]           luma,
    input  logic [7:0]           blue_diff,
    input  logic [7:0]           red_diff,
    input  logic [15:0]          packed_yuv,
    output logic                 out_valid,
    output yuv2rgb_pkg::offs_t   offs
);
    import yuv2rgb_pkg::*;

    logic        valid_reg;
    offs_t       offs_reg;
    offs_t       offs_next;
    logic [7:0]  y_sel;
    logic [7:0]  u_sel;
    logic [7:0]  v_sel;

    // widen a 5-bit sample back to 8 bits by bit replication
    function automatic logic [7:0] expand5(input logic [4:0] s5);
        return {s5, s5[4:2]};
    endfunction

    // source select per mode
    always_comb
    begin
        case (mode)
            MODE_FULL:
            begin
                y_sel = luma;
                u_sel = blue_diff;
                v_sel = red_diff;
            end
            MODE_QUANT:
            begin
                y_sel = expand5(luma[7:3]);
                u_sel = expand5(blue_diff[7:3]);
                v_sel = expand5(red_diff[7:3]);
            end
            default:
            begin
                y_sel = expand5(packed_yuv[14:10]);
                u_sel = expand5(packed_yuv[9:5]);
                v_sel = expand5(packed_yuv[4:0]);
            end
        endcase
    end

    // offset removal
    always_comb
    begin
        offs_next.c = signed'({1'b0, y_sel}) - signed'({1'b0, LUMA_OFFSET});
        offs_next.d = signed'(u_sel ^ CHROMA_OFFSET);
        offs_next.e = signed'(v_sel ^ CHROMA_OFFSET);
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        offs_reg <= offs_next;
    end

    assign out_valid = valid_reg;
    assign offs      = offs_reg;

endmodule

>>> hw/rtl/yuv2rgb_mult.sv
// ----------------------------------------------------------------------------
// yuv2rgb_mult
// Stage 2: forms the five constant-coefficient products.
// ----------------------------------------------------------------------------
module yuv2rgb_mult
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  yuv2rgb_pkg::offs_t   offs,
    output logic                 out_valid,
    output yuv2rgb_pkg::prod_t   prod
);
    import yuv2rgb_pkg::*;

    logic   valid_reg;
    prod_t  prod_reg;
    prod_t  prod_next;

    // constant multiplies, each sized to its exact range
    always_comb
    begin
        prod_next.y_term  = 18'(offs.c) * 18'(COEF_Y);
        prod_next.rv_term = 17'(offs.e) * 17'(COEF_RV);
        prod_next.gu_term = 15'(offs.d) * 15'(COEF_GU);
        prod_next.gv_term = 16'(offs.e) * 16'(COEF_GV);
        prod_next.bu_term = 18'(offs.d) * 18'(COEF_BU);
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

>>> hw/rtl/yuv2rgb_sum_clip.sv
// ----------------------------------------------------------------------------
// yuv2rgb_sum_clip
// Stage 3: sums the terms per channel with rounding, scales by 1/256 with
// floor, clips to 0..255 and packs RGB565.
// ----------------------------------------------------------------------------
module yuv2rgb_sum_clip
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  yuv2rgb_pkg::prod_t   prod,
    output logic                 out_valid,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue,
    output logic [15:0]          rgb565
);
    import yuv2rgb_pkg::*;

    logic               valid_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [15:0]        rgb565_reg;
    logic signed [19:0] r_acc;
    logic signed [19:0] g_acc;
    logic signed [19:0] b_acc;
    logic [7:0]         red_next;
    logic [7:0]         green_next;
    logic [7:0]         blue_next;

    // floor divide by 256 and clip to 0..255
    function automatic logic [7:0] scale_clip(input logic signed [19:0] acc);
        logic signed [11:0] q;
        q = acc[19:8];
        if (q < 12'sd0)
            return 8'd0;
        else if (q > CLIP_MAX)
            return 8'hFF;
        else
            return q[7:0];
    endfunction

    // channel sums
    always_comb
    begin
        r_acc = 20'(prod.y_term) + 20'(prod.rv_term) + 20'(ROUND_BIAS);
        g_acc = 20'(prod.y_term) - 20'(prod.gu_term) - 20'(prod.gv_term)
              + 20'(ROUND_BIAS);
        b_acc = 20'(prod.y_term) + 20'(prod.bu_term) + 20'(ROUND_BIAS);
        red_next   = scale_clip(r_acc);
        green_next = scale_clip(g_acc);
        blue_next  = scale_clip(b_acc);
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        rgb565_reg <= {red_next[7:3], green_next[7:2], blue_next[7:3]};
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign rgb565    = rgb565_reg;

endmodule

>>> hw/rtl/yuv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_converter_core
// BT.601 video-range YUV to RGB888 / RGB565 converter, three-stage pipeline.
//
// usage:
//   - input beat: drive luma, blue_diff, red_diff and packed_yuv and raise
//     start; the beat is taken at any edge where start is high and busy is
//     low. busy is always low, so one pixel can enter every cycle.
//   - result beat: red, green, blue and rgb565 are valid for the single cycle
//     in which done is high; the receiver must take it then.
//   - the result passes through the three register stages (unpack/offset,
//     constant multiply, sum/scale/clip) in that order; throughput one pixel
//     per clock, since no stage ever holds a beat back.
//   - mode_we / mode_wdata write the 2-bit input mode (0 full 8-bit yuv,
//     1 8-bit yuv quantized to 555, 2 or 3 packed yuv555 word); change it
//     only while no pixel is in flight.
//   - reset clears the mode to full 8-bit and empties the pipeline; no
//     clearing pass is needed. the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module yuv_to_rgb_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mode_we,
    input  logic [1:0]  mode_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  luma,
    input  logic [7:0]  blue_diff,
    input  logic [7:0]  red_diff,
    input  logic [15:0] packed_yuv,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [15:0] rgb565
);
    import yuv2rgb_pkg::*;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       accept;
    logic       s1_valid;
    logic       s2_valid;
    offs_t      s1_offs;
    prod_t      s2_prod;

    // mode register
    always_comb
    begin
        mode_next = mode_we ? mode_wdata : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_FULL;
        else
            mode_reg <= mode_next;
    end

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: source select and offsets
    yuv2rgb_unpack u_unpack
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .mode       (mode_reg),
        .luma       (luma),
        .blue_diff  (blue_diff),
        .red_diff   (red_diff),
        .packed_yuv (packed_yuv),
        .out_valid  (s1_valid),
        .offs       (s1_offs)
    );

    // stage 2: coefficient products
    yuv2rgb_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .offs      (s1_offs),
        .out_valid (s2_valid),
        .prod      (s2_prod)
    );

    // stage 3: sum, scale, clip, pack
    yuv2rgb_sum_clip u_sum_clip
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .prod      (s2_prod),
        .out_valid (done),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .rgb565    (rgb565)
    );

    // every accepted beat yields a result beat on done
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted beat did not produce a result");

    // no stage-2 valid without an accepted beat that has passed stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid |-> $past(accept, 2))
        else $error("pipeline valid without a matching input beat");

    // packed output agrees with the 8-bit channels
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rgb565[15:11] == red[7:3]) && (rgb565[10:5] == green[7:2])
                 && (rgb565[4:0] == blue[7:3]))
        else $error("rgb565 packing mismatch");

    // mode follows the last write
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_we |=> mode_reg == $past(mode_wdata))
        else $error("mode register missed a write");

endmodule
